@@ hw/rtl/hdlc_fd_pkg.sv @@
// ----------------------------------------------------------------------------
// HDLC frame decoder package
// Shared constants, codes and struct types for the frame decoder modules.
// ----------------------------------------------------------------------------
package hdlc_fd_pkg;

    localparam int MAX_PAYLOAD = 16;
    localparam int MIN_PAYLOAD = 6;
    localparam int STORE_DEPTH = MAX_PAYLOAD + 2;
    localparam int RESULT_CAP  = 16;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int NBANK       = 2;
    localparam int ADDR_W      = $clog2(NBANK * STORE_DEPTH);
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int PLEN_W      = 5;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0]        FLAG_RST = 8'h7E;
    localparam logic [7:0]        ESC_RST  = 8'h7D;
    localparam logic [7:0]        MASK_RST = 8'h20;
    localparam logic [PLEN_W-1:0] CAP_RST  = PLEN_W'(16);

    localparam logic [1:0] CFG_FLAG     = 2'd0;
    localparam logic [1:0] CFG_ESCAPE   = 2'd1;
    localparam logic [1:0] CFG_MASK     = 2'd2;
    localparam logic [1:0] CFG_CAPACITY = 2'd3;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OVERFLOW = 3'd1,
        ST_SHORT    = 3'd2,
        ST_CRC      = 3'd3,
        ST_CAPACITY = 3'd4
    } status_t;

    typedef struct packed {
        status_t             status;
        logic [PLEN_W-1:0]   plen;
        logic                bank;
    } desc_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } wr_t;

    typedef struct packed {
        logic en;
        logic bank;
    } rel_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_FETCH,
        B_SEND,
        B_ERR
    } back_state_t;

endpackage

@@ hw/rtl/hdlc_fd_queue.sv @@
// ----------------------------------------------------------------------------
// HDLC frame decoder descriptor queue
// Short FIFO of closed-frame descriptors between the front and back parts.
// ----------------------------------------------------------------------------
module hdlc_fd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  hdlc_fd_pkg::desc_t  push_desc,
    input  logic                pop,
    output hdlc_fd_pkg::desc_t  head,
    output logic                empty,
    output logic                full
);

    hdlc_fd_pkg::desc_t                 fifo_reg [hdlc_fd_pkg::QDEPTH];
    logic [hdlc_fd_pkg::QPTR_W-1:0]     wptr_reg, wptr_next;
    logic [hdlc_fd_pkg::QPTR_W-1:0]     rptr_reg, rptr_next;
    logic [hdlc_fd_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == hdlc_fd_pkg::QCNT_W'(hdlc_fd_pkg::QDEPTH));
    assign head  = fifo_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == hdlc_fd_pkg::QPTR_W'(hdlc_fd_pkg::QDEPTH - 1))
                        ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == hdlc_fd_pkg::QPTR_W'(hdlc_fd_pkg::QDEPTH - 1))
                        ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wptr_reg] <= push_desc;
        end
    end

endmodule

@@ hw/rtl/hdlc_fd_front.sv @@
// ----------------------------------------------------------------------------
// HDLC frame decoder front part
// Takes raw bytes, removes escapes, runs the CRC, writes the frame bank and
// classifies each closed frame into a descriptor.
// ----------------------------------------------------------------------------
module hdlc_fd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic                q_full,
    output logic                push,
    output hdlc_fd_pkg::desc_t  push_desc,
    output hdlc_fd_pkg::wr_t    wr,
    input  hdlc_fd_pkg::rel_t   rel
);

    logic [7:0]                         flag_reg, esc_reg, mask_reg;
    logic [hdlc_fd_pkg::PLEN_W-1:0]     cap_reg;

    logic                               in_frame_reg, in_frame_next;
    logic                               pend_reg, pend_next;
    logic                               ovf_reg, ovf_next;
    logic [hdlc_fd_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [15:0]                        crc_reg, crc_next;
    logic                               wbank_reg, wbank_next;
    logic [hdlc_fd_pkg::NBANK-1:0]      busy_reg, busy_next;

    logic                               take;
    logic [7:0]                         b;
    logic [hdlc_fd_pkg::CNT_W:0]        plen_x;
    logic [hdlc_fd_pkg::CNT_W:0]        cap_x;
    logic [hdlc_fd_pkg::PLEN_W-1:0]     cap_eff;
    hdlc_fd_pkg::status_t               st;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        c = crc ^ {d, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ((c << 1) ^ hdlc_fd_pkg::CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full && !busy_reg[wbank_reg];
    assign take      = in_valid && in_ready;
    assign b         = pend_reg ? (rx_byte ^ mask_reg) : rx_byte;

    always_comb
    begin
        cap_eff = (cap_reg > hdlc_fd_pkg::PLEN_W'(hdlc_fd_pkg::RESULT_CAP))
                  ? hdlc_fd_pkg::PLEN_W'(hdlc_fd_pkg::RESULT_CAP) : cap_reg;
        cap_x   = (hdlc_fd_pkg::CNT_W + 1)'(cap_eff);
        plen_x  = {1'b0, cnt_reg} - (hdlc_fd_pkg::CNT_W + 1)'(2);
        if (ovf_reg)
        begin
            st = hdlc_fd_pkg::ST_OVERFLOW;
        end
        else if (cnt_reg < hdlc_fd_pkg::CNT_W'(hdlc_fd_pkg::MIN_PAYLOAD + 2))
        begin
            st = hdlc_fd_pkg::ST_SHORT;
        end
        else if (crc_reg != 16'h0000)
        begin
            st = hdlc_fd_pkg::ST_CRC;
        end
        else if (plen_x > cap_x)
        begin
            st = hdlc_fd_pkg::ST_CAPACITY;
        end
        else
        begin
            st = hdlc_fd_pkg::ST_OK;
        end
        push_desc.status = st;
        push_desc.plen   = (st == hdlc_fd_pkg::ST_OK)
                           ? hdlc_fd_pkg::PLEN_W'(plen_x) : '0;
        push_desc.bank   = wbank_reg;
    end

    always_comb
    begin
        in_frame_next = in_frame_reg;
        pend_next     = pend_reg;
        ovf_next      = ovf_reg;
        cnt_next      = cnt_reg;
        crc_next      = crc_reg;
        wbank_next    = wbank_reg;
        busy_next     = busy_reg;
        push          = 1'b0;
        wr.en         = 1'b0;
        wr.data       = b;
        wr.addr       = wbank_reg
                        ? hdlc_fd_pkg::ADDR_W'(hdlc_fd_pkg::STORE_DEPTH)
                          + hdlc_fd_pkg::ADDR_W'(cnt_reg)
                        : hdlc_fd_pkg::ADDR_W'(cnt_reg);
        if (rel.en)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (take)
        begin
            if (rx_byte == flag_reg)
            begin
                if (in_frame_reg && cnt_reg != '0)
                begin
                    push = 1'b1;
                    if (st == hdlc_fd_pkg::ST_OK)
                    begin
                        busy_next[wbank_reg] = 1'b1;
                        wbank_next           = !wbank_reg;
                    end
                end
                in_frame_next = 1'b1;
                pend_next     = 1'b0;
                ovf_next      = 1'b0;
                cnt_next      = '0;
                crc_next      = hdlc_fd_pkg::CRC_INIT;
            end
            else if (in_frame_reg)
            begin
                if (rx_byte == esc_reg)
                begin
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (cnt_reg < hdlc_fd_pkg::CNT_W'(hdlc_fd_pkg::STORE_DEPTH))
                    begin
                        wr.en    = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                        crc_next = crc_byte(crc_reg, b);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pend_reg     <= 1'b0;
            ovf_reg      <= 1'b0;
            cnt_reg      <= '0;
            crc_reg      <= hdlc_fd_pkg::CRC_INIT;
            wbank_reg    <= 1'b0;
            busy_reg     <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            pend_reg     <= pend_next;
            ovf_reg      <= ovf_next;
            cnt_reg      <= cnt_next;
            crc_reg      <= crc_next;
            wbank_reg    <= wbank_next;
            busy_reg     <= busy_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= hdlc_fd_pkg::FLAG_RST;
            esc_reg  <= hdlc_fd_pkg::ESC_RST;
            mask_reg <= hdlc_fd_pkg::MASK_RST;
            cap_reg  <= hdlc_fd_pkg::CAP_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                hdlc_fd_pkg::CFG_FLAG:     flag_reg <= cfg_data;
                hdlc_fd_pkg::CFG_ESCAPE:   esc_reg  <= cfg_data;
                hdlc_fd_pkg::CFG_MASK:     mask_reg <= cfg_data;
                hdlc_fd_pkg::CFG_CAPACITY: cap_reg  <= cfg_data[hdlc_fd_pkg::PLEN_W-1:0];
                default:                   ;
            endcase
        end
    end

endmodule

@@ hw/rtl/hdlc_fd_back.sv @@
// ----------------------------------------------------------------------------
// HDLC frame decoder back part
// Holds the two frame banks and turns each descriptor into result beats.
// ----------------------------------------------------------------------------
module hdlc_fd_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  hdlc_fd_pkg::wr_t                wr,
    input  hdlc_fd_pkg::desc_t              head,
    input  logic                            q_empty,
    output logic                            pop,
    output hdlc_fd_pkg::rel_t               rel,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0]                      status,
    output logic [7:0]                      data_byte,
    output logic                            last,
    output logic [hdlc_fd_pkg::PLEN_W-1:0]  payload_length
);

    logic [7:0]                      store_reg [hdlc_fd_pkg::NBANK * hdlc_fd_pkg::STORE_DEPTH];
    logic [7:0]                      rd_reg;
    hdlc_fd_pkg::back_state_t        state_reg, state_next;
    hdlc_fd_pkg::desc_t              desc_reg, desc_next;
    logic [hdlc_fd_pkg::PLEN_W-1:0]  idx_reg, idx_next;
    logic                            rd_en;
    logic                            is_last;
    logic [hdlc_fd_pkg::ADDR_W-1:0]  rd_addr;

    assign is_last = (idx_reg == desc_reg.plen - 1'b1);
    assign rd_addr = desc_reg.bank
                     ? hdlc_fd_pkg::ADDR_W'(hdlc_fd_pkg::STORE_DEPTH)
                       + hdlc_fd_pkg::ADDR_W'(idx_reg)
                     : hdlc_fd_pkg::ADDR_W'(idx_reg);

    always_comb
    begin
        state_next = state_reg;
        desc_next  = desc_reg;
        idx_next   = idx_reg;
        case (state_reg)
            hdlc_fd_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    desc_next  = head;
                    idx_next   = '0;
                    state_next = (head.status == hdlc_fd_pkg::ST_OK)
                                 ? hdlc_fd_pkg::B_FETCH : hdlc_fd_pkg::B_ERR;
                end
            end
            hdlc_fd_pkg::B_FETCH:
            begin
                state_next = hdlc_fd_pkg::B_SEND;
            end
            hdlc_fd_pkg::B_SEND:
            begin
                if (out_ready)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = is_last ? hdlc_fd_pkg::B_IDLE : hdlc_fd_pkg::B_FETCH;
                end
            end
            hdlc_fd_pkg::B_ERR:
            begin
                if (out_ready)
                begin
                    state_next = hdlc_fd_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = hdlc_fd_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop            = 1'b0;
        rd_en          = 1'b0;
        rel.en         = 1'b0;
        rel.bank       = desc_reg.bank;
        out_valid      = 1'b0;
        status         = hdlc_fd_pkg::ST_OK;
        data_byte      = 8'h00;
        last           = 1'b0;
        payload_length = '0;
        case (state_reg)
            hdlc_fd_pkg::B_IDLE:
            begin
                pop = !q_empty;
            end
            hdlc_fd_pkg::B_FETCH:
            begin
                rd_en = 1'b1;
            end
            hdlc_fd_pkg::B_SEND:
            begin
                out_valid      = 1'b1;
                data_byte      = rd_reg;
                last           = is_last;
                payload_length = desc_reg.plen;
                rel.en         = out_ready && is_last;
            end
            hdlc_fd_pkg::B_ERR:
            begin
                out_valid = 1'b1;
                status    = desc_reg.status;
                last      = 1'b1;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hdlc_fd_pkg::B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
        idx_reg  <= idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store_reg[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_reg <= store_reg[rd_addr];
        end
    end

endmodule

@@ hw/rtl/hdlc_frame_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// HDLC frame decoder
// Byte-stuffed frame receiver with CRC-16/CCITT-FALSE check and payload
// delivery.
// ----------------------------------------------------------------------------
// Raw link bytes are taken at one byte per cycle. A closing flag hands a
// descriptor to a two-entry queue; a good frame also claims one of two frame
// banks, so reception of the next frame overlaps delivery of the last one.
// Input stalls only while both banks are still draining or the queue is full.
// Each payload byte is first read into a register from the frame bank in the
// fetch state, then sent as an output beat; an error frame yields one beat. No
// configuration write should be made while frames are in flight.
// ----------------------------------------------------------------------------
module hdlc_frame_decoder_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      rx_byte,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [7:0]                      cfg_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0]                      status,
    output logic [7:0]                      data_byte,
    output logic                            last,
    output logic [hdlc_fd_pkg::PLEN_W-1:0]  payload_length
);

    logic                 push;
    logic                 pop;
    logic                 q_empty;
    logic                 q_full;
    hdlc_fd_pkg::desc_t   push_desc;
    hdlc_fd_pkg::desc_t   head;
    hdlc_fd_pkg::wr_t     wr;
    hdlc_fd_pkg::rel_t    rel;

    hdlc_fd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc),
        .wr        (wr),
        .rel       (rel)
    );

    hdlc_fd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    hdlc_fd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr             (wr),
        .head           (head),
        .q_empty        (q_empty),
        .pop            (pop),
        .rel            (rel),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .data_byte      (data_byte),
        .last           (last),
        .payload_length (payload_length)
    );

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// HDLC frame decoder testbench
// Feeds byte-stuffed frames, broken frames and line noise through the frame
// decoder under several delimiter, escape and capacity settings. A local
// deframer predicts each delivered beat and the monitor checks every field.
// ----------------------------------------------------------------------------
module testbench;

    typedef logic [7:0] byte_q_t[$];

    typedef struct {
        hdlc_fd_pkg::status_t           status;
        logic [7:0]                     data;
        logic                           last;
        logic [hdlc_fd_pkg::PLEN_W-1:0] plen;
    } beat_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [7:0]                     rx_byte = 8'h00;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [1:0]                     cfg_index = hdlc_fd_pkg::CFG_FLAG;
    logic [7:0]                     cfg_data = 8'h00;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [2:0]                     status;
    logic [7:0]                     data_byte;
    logic                           last;
    logic [hdlc_fd_pkg::PLEN_W-1:0] payload_length;

    // deframer state and register copies
    logic [7:0]                     reg_flag = hdlc_fd_pkg::FLAG_RST;
    logic [7:0]                     reg_esc = hdlc_fd_pkg::ESC_RST;
    logic [7:0]                     reg_mask = hdlc_fd_pkg::MASK_RST;
    logic [hdlc_fd_pkg::PLEN_W-1:0] reg_cap = hdlc_fd_pkg::CAP_RST;
    bit                             framing = 1'b0;
    bit                             esc_armed = 1'b0;
    bit                             ovf_seen = 1'b0;
    int                             fill = 0;
    logic [15:0]                    crc_acc = hdlc_fd_pkg::CRC_INIT;
    logic [7:0]                     store [hdlc_fd_pkg::STORE_DEPTH];

    byte_q_t           link_bytes;
    beat_t             due_beats[$];
    int                errors = 0;
    int                idle_pct = 20;
    int                send_gap = 0;
    int                recv_gap = 0;
    bit                hold_go = 1'b0;
    logic              rx_hold = 1'b0;

    hdlc_frame_decoder_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .data_byte      (data_byte),
        .last           (last),
        .payload_length (payload_length)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ((c << 1) ^ hdlc_fd_pkg::CRC_POLY) : (c << 1);
        return c;
    endfunction

    task automatic deframe_byte(input logic [7:0] b_in);
        logic [7:0]           b;
        hdlc_fd_pkg::status_t fail;
        int                   plen;
        int                   cap;
        b = b_in;
        if (b == reg_flag)
        begin
            if (framing && fill != 0)
            begin
                plen = fill - 2;
                cap = (reg_cap > hdlc_fd_pkg::RESULT_CAP) ? hdlc_fd_pkg::RESULT_CAP
                                                          : int'(reg_cap);
                fail = hdlc_fd_pkg::ST_OK;
                if (ovf_seen)
                    fail = hdlc_fd_pkg::ST_OVERFLOW;
                else if (fill < hdlc_fd_pkg::MIN_PAYLOAD + 2)
                    fail = hdlc_fd_pkg::ST_SHORT;
                else if (crc_acc != 16'h0000)
                    fail = hdlc_fd_pkg::ST_CRC;
                else if (plen > cap)
                    fail = hdlc_fd_pkg::ST_CAPACITY;
                if (fail != hdlc_fd_pkg::ST_OK)
                    due_beats.push_back('{status: fail, data: 8'h00, last: 1'b1, plen: '0});
                else
                    for (int i = 0; i < plen; i++)
                        due_beats.push_back('{status: hdlc_fd_pkg::ST_OK, data: store[i],
                                              last: (i == plen - 1),
                                              plen: hdlc_fd_pkg::PLEN_W'(plen)});
            end
            framing = 1'b1;
            esc_armed = 1'b0;
            ovf_seen = 1'b0;
            fill = 0;
            crc_acc = hdlc_fd_pkg::CRC_INIT;
        end
        else if (framing)
        begin
            if (b == reg_esc)
                esc_armed = 1'b1;
            else
            begin
                if (esc_armed)
                begin
                    b = b ^ reg_mask;
                    esc_armed = 1'b0;
                end
                if (fill < hdlc_fd_pkg::STORE_DEPTH)
                begin
                    store[fill] = b;
                    fill++;
                    crc_acc = crc16_step(crc_acc, b);
                end
                else
                    ovf_seen = 1'b1;
            end
        end
    endtask

    task automatic check_beat();
        beat_t want;
        if (due_beats.size() == 0)
        begin
            $display("%0t unexpected beat: status %0d data %02h last %0d length %0d",
                     $time, status, data_byte, last, payload_length);
            errors++;
        end
        else
        begin
            want = due_beats.pop_front();
            if (status !== want.status)
            begin
                $display("%0t status: expected %0d, actual %0d", $time, want.status, status);
                errors++;
            end
            if (data_byte !== want.data)
            begin
                $display("%0t data_byte: expected %02h, actual %02h", $time, want.data, data_byte);
                errors++;
            end
            if (last !== want.last)
            begin
                $display("%0t last: expected %0d, actual %0d", $time, want.last, last);
                errors++;
            end
            if (payload_length !== want.plen)
            begin
                $display("%0t payload_length: expected %0d, actual %0d",
                         $time, want.plen, payload_length);
                errors++;
            end
        end
    endtask

    // driver: one beat per handshake, random gaps between beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte <= 8'h00;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                deframe_byte(rx_byte);
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if ($urandom_range(0, 99) < idle_pct)
                begin
                    send_gap <= $urandom_range(0, 14);
                    in_valid <= 1'b0;
                end
                else if (link_bytes.size() != 0)
                begin
                    rx_byte <= link_bytes.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_beat();
            if (rx_hold)
                out_ready <= 1'b0;
            else if (recv_gap != 0)
            begin
                recv_gap <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < idle_pct)
            begin
                recv_gap <= $urandom_range(0, 14);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // long receiver hold-off so the decoder backs up and stalls its input
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic put_byte(input logic [7:0] b);
        link_bytes.push_back(b);
    endtask

    function automatic logic [7:0] link_symbol();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? reg_flag : reg_esc;
        return 8'($urandom);
    endfunction

    task automatic send_payload(input byte_q_t pl, input bit bad_crc);
        logic [15:0] crc;
        crc = hdlc_fd_pkg::CRC_INIT;
        foreach (pl[i])
            crc = crc16_step(crc, pl[i]);
        if (bad_crc)
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        pl.push_back(crc[15:8]);
        pl.push_back(crc[7:0]);
        put_byte(reg_flag);
        foreach (pl[i])
        begin
            if (pl[i] == reg_flag || pl[i] == reg_esc)
            begin
                put_byte(reg_esc);
                put_byte(pl[i] ^ reg_mask);
            end
            else
                put_byte(pl[i]);
        end
        put_byte(reg_flag);
    endtask

    task automatic random_frame(input int plen, input bit bad_crc);
        byte_q_t pl;
        repeat (plen) pl.push_back(link_symbol());
        send_payload(pl, bad_crc);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            hdlc_fd_pkg::CFG_FLAG:     reg_flag = val;
            hdlc_fd_pkg::CFG_ESCAPE:   reg_esc = val;
            hdlc_fd_pkg::CFG_MASK:     reg_mask = val;
            hdlc_fd_pkg::CFG_CAPACITY: reg_cap = val[hdlc_fd_pkg::PLEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [7:0] f, input logic [7:0] e, input logic [7:0] m,
                            input logic [7:0] c);
        write_reg(hdlc_fd_pkg::CFG_FLAG, f);
        write_reg(hdlc_fd_pkg::CFG_ESCAPE, e);
        write_reg(hdlc_fd_pkg::CFG_MASK, m);
        write_reg(hdlc_fd_pkg::CFG_CAPACITY, c);
        @(negedge clk);
    endtask

    // wait for the pipeline to drain before touching the registers
    task automatic settle();
        while (link_bytes.size() != 0 || in_valid || due_beats.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    initial
    begin
        byte_q_t pl;
        foreach (store[i])
            store[i] = 8'h00;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: noise before the first flag, empty frame, stuffed payload,
        // double escape and an escape left pending at the closing flag
        set_regs(hdlc_fd_pkg::FLAG_RST, hdlc_fd_pkg::ESC_RST, hdlc_fd_pkg::MASK_RST, 8'd16);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(reg_flag);
        put_byte(reg_flag);
        pl = {8'h7E, 8'h7D, 8'h00, 8'hFF, 8'h55, 8'hAA};
        send_payload(pl, 1'b0);
        put_byte(8'h41);
        put_byte(reg_esc);
        put_byte(reg_esc);
        put_byte(8'h42);
        put_byte(reg_esc);
        put_byte(reg_flag);
        settle();

        // overflow and bad check
        set_regs(8'hFF, 8'h00, 8'h01, 8'hFF);
        random_frame(17, 1'b0);
        random_frame(hdlc_fd_pkg::MIN_PAYLOAD, 1'b1);
        settle();

        // zero capacity: a good frame is refused
        set_regs(8'h00, 8'hFF, 8'h80, 8'h00);
        random_frame(6, 1'b0);
        settle();

        // flag equal to escape
        set_regs(8'h7E, 8'h7E, 8'hFF, 8'd16);
        repeat (2) put_byte(link_symbol());
        random_frame(6, 1'b0);
        settle();

        // back-pressure at full rate: capacity above the result limit, a full
        // store, and the receiver held while frames keep arriving
        set_regs(hdlc_fd_pkg::FLAG_RST, hdlc_fd_pkg::ESC_RST, hdlc_fd_pkg::MASK_RST, 8'hFF);
        idle_pct = 0;
        hold_go = 1'b1;
        random_frame(16, 1'b0);
        repeat (2) random_frame(hdlc_fd_pkg::MIN_PAYLOAD, 1'b0);
        settle();

        if (errors == 0 && due_beats.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

@@ files.f @@
hw/rtl/hdlc_fd_pkg.sv
hw/rtl/hdlc_fd_queue.sv
hw/rtl/hdlc_fd_front.sv
hw/rtl/hdlc_fd_back.sv
hw/rtl/hdlc_frame_decoder_unit.sv
tb/sv/testbench.sv
